[design/ccs_pkg.sv]
package ccs_pkg;

    localparam int LEN_W      = 9;
    localparam int CNT_W      = 13;
    localparam int IN_LINE_W  = 13;
    localparam int OUT_LINE_W = 12;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int COUNT_W    = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [LEN_W-1:0]   LEN_MIN   = 9'd3;
    localparam logic [LEN_W-1:0]   LEN_RESET = 9'd64;
    localparam logic [CNT_W-1:0]   CNT_MIN   = 13'd3;
    localparam logic [CNT_W-1:0]   CNT_MAX   = 13'd4096;
    localparam logic [CNT_W-1:0]   CNT_RESET = 13'd64;
    localparam logic [COUNT_W-1:0] KEEP_COUNT = 4'd4;
    localparam logic [COUNT_W-1:0] BORDER_ROW_COUNT = 4'd3;

    localparam logic MODE_CELL  = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_LENGTH = 1'b0,
        REG_LINE_COUNT  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic mode;
        logic cell_req;
    } t_in_item;

    typedef struct packed {
        logic smoothed;
        logic last;
    } t_out_item;

    typedef struct packed {
        logic act;
        logic raw_wr;
        logic x_first;
        logic y_first;
        logic line_end;
        logic calc;
        logic last;
        logic v;
        logic recent;
        logic older;
    } t_cmd_flags;

endpackage

[design/ccs_front.sv]
module ccs_front
    import ccs_pkg::*;
#(
    parameter int MAX_LINE = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_wdata,
    input  logic                          i_valid,
    input  t_in_item                      i_data,
    input  logic                          i_full,
    output logic                          o_push,
    output t_cmd_flags                    o_flags,
    output logic [$clog2(MAX_LINE)-1:0]   o_wr_col,
    output logic [$clog2(MAX_LINE)-1:0]   o_rd_col
);

    localparam int CW   = $clog2(MAX_LINE);
    localparam int PW   = CW + 1;
    localparam int NW   = $clog2(MAX_LINE + 1);
    localparam int CMPW = (NW > LEN_W) ? NW : LEN_W;

    logic [LEN_W-1:0]      r_line_length;
    logic [CNT_W-1:0]      r_line_count;
    logic [IN_LINE_W-1:0]  r_in_line;
    logic [CW-1:0]         r_in_cell;
    logic [OUT_LINE_W-1:0] r_out_line;
    logic [CW-1:0]         r_out_cell;
    logic [1:0]            r_win;

    logic [CMPW-1:0]  len_ext;
    logic [NW-1:0]    n_len;
    logic [PW-1:0]    n_p;
    logic [CNT_W-1:0] n_cnt;
    logic             acc;
    logic             active;
    logic             is_cell;
    logic             v;
    logic [PW-1:0]    in_nxt;
    logic [PW-1:0]    y_nxt;
    logic             line_end;
    logic [CNT_W-1:0] x_ext;
    logic [CNT_W-1:0] x_nxt;
    logic             map_last;

    function automatic logic [CW-1:0] slot(input logic [PW-1:0] c);
        if (c >= PW'(MAX_LINE)) begin
            return CW'(MAX_LINE - 1);
        end else begin
            return c[CW-1:0];
        end
    endfunction

    always_comb begin
        len_ext = CMPW'(r_line_length);
        if (len_ext < CMPW'(LEN_MIN)) begin
            n_len = NW'(LEN_MIN);
        end else if (len_ext > CMPW'(MAX_LINE)) begin
            n_len = NW'(MAX_LINE);
        end else begin
            n_len = NW'(len_ext);
        end
        n_p = PW'(n_len);

        if (r_line_count < CNT_MIN) begin
            n_cnt = CNT_MIN;
        end else if (r_line_count > CNT_MAX) begin
            n_cnt = CNT_MAX;
        end else begin
            n_cnt = r_line_count;
        end
    end

    assign acc      = i_valid && !i_full;
    assign active   = (r_in_line >= IN_LINE_W'(2)) ||
                      (r_in_line == IN_LINE_W'(1) && r_in_cell != '0);
    assign is_cell  = r_in_line < n_cnt;
    assign v        = is_cell && (i_data.mode == MODE_CELL) && i_data.cell_req;
    assign in_nxt   = PW'(r_in_cell) + PW'(1);
    assign y_nxt    = PW'(r_out_cell) + PW'(1);
    assign line_end = y_nxt >= n_p;
    assign x_ext    = CNT_W'(r_out_line);
    assign x_nxt    = x_ext + CNT_W'(1);
    assign map_last = (x_ext >= n_cnt) || (x_nxt >= n_cnt && line_end);

    always_comb begin
        o_flags.act      = active;
        o_flags.raw_wr   = !active && (r_in_line == '0);
        o_flags.x_first  = (r_out_line == '0);
        o_flags.y_first  = (r_out_cell == '0);
        o_flags.line_end = line_end;
        o_flags.calc     = (x_nxt < n_cnt) && !line_end;
        o_flags.last     = map_last;
        o_flags.v        = v;
        o_flags.recent   = r_win[0];
        o_flags.older    = r_win[1];
        o_wr_col         = active ? slot(PW'(r_out_cell)) : slot(PW'(r_in_cell));
        o_rd_col         = slot(y_nxt);
    end

    assign o_push = acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LEN_RESET;
            r_line_count  <= CNT_RESET;
            r_in_line     <= '0;
            r_in_cell     <= '0;
            r_out_line    <= '0;
            r_out_cell    <= '0;
            r_win         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_LINE_LENGTH: r_line_length <= i_cfg_wdata[LEN_W-1:0];
                    REG_LINE_COUNT:  r_line_count  <= i_cfg_wdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (acc) begin
                if (active && map_last) begin
                    r_in_line  <= '0;
                    r_in_cell  <= '0;
                    r_out_line <= '0;
                    r_out_cell <= '0;
                    r_win      <= '0;
                end else begin
                    if (active) begin
                        if (line_end) begin
                            r_out_cell <= '0;
                            r_out_line <= r_out_line + OUT_LINE_W'(1);
                        end else begin
                            r_out_cell <= y_nxt[CW-1:0];
                        end
                    end
                    r_win <= {r_win[0], v};
                    if (in_nxt >= n_p) begin
                        r_in_cell <= '0;
                        r_in_line <= r_in_line + IN_LINE_W'(1);
                    end else begin
                        r_in_cell <= in_nxt[CW-1:0];
                    end
                end
            end
        end
    end

endmodule

[design/ccs_queue.sv]
module ccs_queue
    import ccs_pkg::*;
#(
    parameter int W     = 1,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_valid,
    output logic         o_full,
    output logic [W-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [NW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

endmodule

[design/ccs_back.sv]
module ccs_back
    import ccs_pkg::*;
#(
    parameter int MAX_LINE = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  t_cmd_flags                  i_q_flags,
    input  logic [$clog2(MAX_LINE)-1:0] i_q_wr_col,
    input  logic [$clog2(MAX_LINE)-1:0] i_q_rd_col,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output t_out_item                   o_data
);

    localparam int CW = $clog2(MAX_LINE);

    logic          r_raw_mem  [MAX_LINE];
    logic          r_prev_mem [MAX_LINE];

    logic          r_b1_valid;
    t_cmd_flags    r_b1_flags;
    logic [CW-1:0] r_b1_wr_col;
    logic          r_rd_raw;
    logic          r_rd_prev;
    logic          r_raw0;
    logic          r_raw_hold;
    logic          r_p0;
    logic          r_pl;
    logic          r_pm;
    logic          r_left;
    logic          r_pend;
    logic [CW-1:0] r_pend_col;
    logic          r_out_valid;
    t_out_item     r_out_data;

    logic               out_ready;
    logic               fire;
    logic               here;
    logic               pm;
    logic [COUNT_W-1:0] up_cnt;
    logic [COUNT_W-1:0] cnt;
    logic               result;
    logic               raw_we;
    logic [CW-1:0]      raw_wa;
    logic               raw_wd;
    logic               prev_we;
    logic [CW-1:0]      prev_wa;
    logic               prev_wd;

    assign out_ready = !r_out_valid || !i_stall;
    assign fire      = r_b1_valid && (!r_b1_flags.act || out_ready);
    assign o_pop     = i_q_valid && (!r_b1_valid || fire);

    always_comb begin
        here   = r_b1_flags.y_first ? r_raw0 : r_raw_hold;
        pm     = r_b1_flags.y_first ? r_p0 : r_pm;
        up_cnt = r_b1_flags.x_first ? BORDER_ROW_COUNT
               : COUNT_W'(r_b1_flags.y_first | r_pl) + COUNT_W'(pm) + COUNT_W'(r_rd_prev);
        cnt    = up_cnt
               + COUNT_W'(r_b1_flags.y_first | r_left)
               + COUNT_W'(r_rd_raw)
               + COUNT_W'(r_b1_flags.y_first | r_b1_flags.older)
               + COUNT_W'(r_b1_flags.recent)
               + COUNT_W'(r_b1_flags.v);
        if (!r_b1_flags.calc) begin
            result = here;
        end else if (cnt > KEEP_COUNT) begin
            result = 1'b1;
        end else if (cnt < KEEP_COUNT) begin
            result = 1'b0;
        end else begin
            result = here;
        end

        raw_we  = fire && (r_b1_flags.act || r_b1_flags.raw_wr);
        raw_wa  = r_b1_wr_col;
        raw_wd  = r_b1_flags.act ? r_b1_flags.recent : r_b1_flags.v;

        // end-of-line cell of the smoothed line is written one step late
        prev_we = fire && r_b1_flags.act && (!r_b1_flags.y_first || r_pend);
        prev_wa = r_b1_flags.y_first ? r_pend_col : r_b1_wr_col - CW'(1);
        prev_wd = r_left;
    end

    always_ff @(posedge i_clk) begin
        if (raw_we) begin
            r_raw_mem[raw_wa] <= raw_wd;
        end
        if (prev_we) begin
            r_prev_mem[prev_wa] <= prev_wd;
        end
        if (o_pop) begin
            r_rd_raw  <= (raw_we && raw_wa == i_q_rd_col) ? raw_wd : r_raw_mem[i_q_rd_col];
            r_rd_prev <= (prev_we && prev_wa == i_q_rd_col) ? prev_wd
                                                            : r_prev_mem[i_q_rd_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b1_flags  <= i_q_flags;
            r_b1_wr_col <= i_q_wr_col;
        end
        if (raw_we && raw_wa == '0) begin
            r_raw0 <= raw_wd;
        end
        if (prev_we && prev_wa == '0) begin
            r_p0 <= prev_wd;
        end
        if (fire && r_b1_flags.act) begin
            r_raw_hold <= r_rd_raw;
            r_pl       <= pm;
            r_pm       <= r_rd_prev;
            r_left     <= result;
            r_out_data <= '{smoothed: result, last: r_b1_flags.last};
            if (r_b1_flags.line_end) begin
                r_pend_col <= r_b1_wr_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            if (o_pop) begin
                r_b1_valid <= 1'b1;
            end else if (fire) begin
                r_b1_valid <= 1'b0;
            end
            if (fire && r_b1_flags.act) begin
                r_out_valid <= 1'b1;
                if (r_b1_flags.line_end) begin
                    r_pend <= 1'b1;
                end else if (r_b1_flags.y_first) begin
                    r_pend <= 1'b0;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

[design/cave_cellular_smoothing_top.sv]
// One streamed pass of 4-5 rule cave smoothing over a binary wall map sent in scan order,
// line by line. The block takes one transaction per clock cycle while the output is not
// stalled: the front end tracks map position and queues one command per transaction
// (4 deep), and the back end does the whole 8-neighbour count of a cell combinationally
// with a single read and a single write per line buffer (two 1-bit buffers of MAX_LINE
// entries), so one cell leaves per cycle while the output is not stalled. A result passes
// through the queue, the back-end command register and the output register; it is tied
// to the cell one line plus one cell earlier in the stream: a map of N cells per line and
// L lines needs N*L cell transactions followed by N+1 flush transactions, and the final
// result carries last. Out-of-map neighbours count as walls; the last line and last
// column pass through unchanged. Line length and count registers apply at once and must
// be written only while the block is idle; no initialization pass is needed after reset.
module cave_cellular_smoothing_top
    import ccs_pkg::*;
#(
    parameter int MAX_LINE = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data
);

    localparam int CW = $clog2(MAX_LINE);
    localparam int FW = $bits(t_cmd_flags);
    localparam int QW = FW + 2 * CW;

    logic          push;
    t_cmd_flags    f_flags;
    logic [CW-1:0] f_wr_col;
    logic [CW-1:0] f_rd_col;
    logic [QW-1:0] q_din;
    logic [QW-1:0] q_dout;
    logic          q_valid;
    logic          q_full;
    logic          pop;
    t_cmd_flags    q_flags;
    logic [CW-1:0] q_wr_col;
    logic [CW-1:0] q_rd_col;

    ccs_front #(.MAX_LINE(MAX_LINE)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_in_valid),
        .i_data      (i_in_data),
        .i_full      (q_full),
        .o_push      (push),
        .o_flags     (f_flags),
        .o_wr_col    (f_wr_col),
        .o_rd_col    (f_rd_col)
    );

    assign q_din = {f_flags, f_wr_col, f_rd_col};

    ccs_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_din),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_dout)
    );

    assign q_flags  = t_cmd_flags'(q_dout[QW-1 -: FW]);
    assign q_wr_col = q_dout[2*CW-1 -: CW];
    assign q_rd_col = q_dout[CW-1:0];

    ccs_back #(.MAX_LINE(MAX_LINE)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_flags  (q_flags),
        .i_q_wr_col (q_wr_col),
        .i_q_rd_col (q_rd_col),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_data     (o_out_data)
    );

    assign o_in_stall = q_full;

endmodule

[design/ccs_checker.sv]
module ccs_checker
    import ccs_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_stall,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_item i_out_data
);

    // reset empties the queue and the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_stall)
        else $error("valid or stall high after reset");

    // the queue only fills while the output side holds back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_in_stall) |-> $past(i_out_valid && i_out_stall && i_in_valid))
        else $error("input stall without output back pressure");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

endmodule

bind cave_cellular_smoothing_top ccs_checker u_ccs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
